### rtl/hsv2rgb_pkg.sv
// Shared types, constants and helper functions for the HSV to RGB converter.
package hsv2rgb_pkg;

    localparam int HUE_W  = 15;
    localparam int FRAC_W = 9;
    localparam int CHAN_W = 8;

    localparam logic [FRAC_W-1:0] FX_ONE       = 9'd256;
    localparam logic [11:0]       SECTOR_UNITS = 12'd3840;
    localparam logic [HUE_W-1:0]  HUE_FULL     = 15'd23040;
    // 256 * 3840: one full unit of the sector-scaled fraction
    localparam logic [19:0]       FULL_SCALE   = 20'd983040;
    // ceil(2^16 / 15); exact floor(y / 15) for y below 4096
    localparam logic [12:0]       RECIP15      = 13'd4370;

    // 60-degree hue sectors, red at sector zero
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    // hue is already below HUE_FULL
    function automatic t_sector sector_of(input logic [HUE_W-1:0] hue);
        t_sector sec;
        if (hue >= 15'd19200)      sec = SEC_MAG_RED;
        else if (hue >= 15'd15360) sec = SEC_BLU_MAG;
        else if (hue >= 15'd11520) sec = SEC_CYN_BLU;
        else if (hue >= 15'd7680)  sec = SEC_GRN_CYN;
        else if (hue >= 15'd3840)  sec = SEC_YEL_GRN;
        else                       sec = SEC_RED_YEL;
        return sec;
    endfunction

    function automatic logic [HUE_W-1:0] sector_base(input t_sector sec);
        logic [HUE_W-1:0] base;
        case (sec)
            SEC_YEL_GRN: base = 15'd3840;
            SEC_GRN_CYN: base = 15'd7680;
            SEC_CYN_BLU: base = 15'd11520;
            SEC_BLU_MAG: base = 15'd15360;
            SEC_MAG_RED: base = 15'd19200;
            default:     base = 15'd0;
        endcase
        return base;
    endfunction

endpackage

### rtl/hsv2rgb_if.sv
// Valid/ready channel interfaces for HSV pixel beats and RGB pixel beats.
interface hsv2rgb_in_if import hsv2rgb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] saturation;
    logic [FRAC_W-1:0] brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_out_if import hsv2rgb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

### rtl/hsv2rgb_chan.sv
// Two-stage scale of a v*n product to an 8-bit channel: floor(255*m / (15*2^24)).
module hsv2rgb_chan
    import hsv2rgb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [27:0]       i_prod,
    output logic [CHAN_W-1:0] o_chan
);

    logic [35:0] n_x255;
    logic [11:0] r_y;
    logic [24:0] n_z;
    logic [CHAN_W-1:0] r_chan;

    // 255*m = 256*m - m; then drop 2^24
    assign n_x255 = {i_prod, 8'd0} - {8'd0, i_prod};
    // divide by 15 through the reciprocal
    assign n_z    = {13'd0, r_y} * {12'd0, RECIP15};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y    <= n_x255[35:24];
            r_chan <= n_z[23:16];
        end
    end

    assign o_chan = r_chan;

endmodule

### rtl/hsv_to_rgb_converter.sv
// HSV to 8-bit RGB pixel converter, six-stage pipeline.
// One pixel beat in per clock unless the output stalls, one RGB beat out per
// pixel, in order. Hue is in 1/64 degree units (23040 and above read as zero),
// saturation and brightness are fractions with 256 = 1.0 (larger codes clamp
// to 1.0). Each channel is the exact floor of 255 times its HSV fraction. The
// whole pipeline advances together whenever the output register is empty or
// being taken, so i_hsv.ready follows o_rgb.ready combinationally; holding
// o_rgb.ready low while a beat waits in the output register freezes every
// stage without losing a beat. Stages: 1 clamp and sector split, 2 the s*r,
// s*(3840-r) and (256-s)*3840 multiplies, 3 the multiply by brightness, 4-5
// the scale by 255/(15*2^24) in each channel unit, 6 the sector swizzle into
// the output.
module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    hsv2rgb_in_if.sink     i_hsv,
    hsv2rgb_out_if.source  o_rgb
);

    localparam int STAGES = 6;

    logic              en;
    logic [STAGES-1:0] r_vld;

    // Pipeline moves as one when the output slot is free or drains.
    assign en          = ~r_vld[STAGES-1] | o_rgb.ready;
    assign i_hsv.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[STAGES-2:0], i_hsv.valid};
        end
    end

    // ---- stage 1: clamp, wrap hue, split into sector and position
    logic [FRAC_W-1:0] n1_s, n1_v;
    logic [HUE_W-1:0]  n1_hue;
    t_sector           n1_sec;
    logic [HUE_W-1:0]  n1_rem;
    logic [FRAC_W-1:0] r1_s, r1_v;
    t_sector           r1_sec;
    logic [11:0]       r1_r;

    always_comb begin
        n1_s   = (i_hsv.saturation > FX_ONE) ? FX_ONE : i_hsv.saturation;
        n1_v   = (i_hsv.brightness > FX_ONE) ? FX_ONE : i_hsv.brightness;
        n1_hue = (i_hsv.hue >= HUE_FULL) ? '0 : i_hsv.hue;
        n1_sec = sector_of(n1_hue);
        n1_rem = n1_hue - sector_base(n1_sec);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_s   <= n1_s;
            r1_v   <= n1_v;
            r1_sec <= n1_sec;
            r1_r   <= n1_rem[11:0];
        end
    end

    // ---- stage 2: sector-scaled numerators for p, q and t
    logic [19:0]       n2_sr, n2_srt, n2_np;
    logic [19:0]       r2_nq, r2_nt, r2_np;
    logic [FRAC_W-1:0] r2_v;
    t_sector           r2_sec;

    always_comb begin
        n2_sr  = 20'(r1_s) * 20'(r1_r);
        n2_srt = 20'(r1_s) * 20'(SECTOR_UNITS - r1_r);
        n2_np  = 20'(FX_ONE - r1_s) * 20'(SECTOR_UNITS);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_nq  <= FULL_SCALE - n2_sr;
            r2_nt  <= FULL_SCALE - n2_srt;
            r2_np  <= n2_np;
            r2_v   <= r1_v;
            r2_sec <= r1_sec;
        end
    end

    // ---- stage 3: times brightness
    logic [27:0]       r3_mq, r3_mt, r3_mp;
    logic [FRAC_W-1:0] r3_v;
    t_sector           r3_sec;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_mq  <= 28'(r2_v) * 28'(r2_nq);
            r3_mt  <= 28'(r2_v) * 28'(r2_nt);
            r3_mp  <= 28'(r2_v) * 28'(r2_np);
            r3_v   <= r2_v;
            r3_sec <= r2_sec;
        end
    end

    // ---- stages 4-5: channel scaling; full-value channel alongside
    logic [CHAN_W-1:0] cq, ct, cp;
    logic [16:0]       n4_v255;
    logic [CHAN_W-1:0] r4_cv, r5_cv;
    t_sector           r4_sec, r5_sec;

    hsv2rgb_chan u_chan_q (.i_clk(i_clk), .i_en(en), .i_prod(r3_mq), .o_chan(cq));
    hsv2rgb_chan u_chan_t (.i_clk(i_clk), .i_en(en), .i_prod(r3_mt), .o_chan(ct));
    hsv2rgb_chan u_chan_p (.i_clk(i_clk), .i_en(en), .i_prod(r3_mp), .o_chan(cp));

    // floor(255*v/256)
    assign n4_v255 = {r3_v, 8'd0} - {8'd0, r3_v};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_cv  <= n4_v255[15:8];
            r4_sec <= r3_sec;
            r5_cv  <= r4_cv;
            r5_sec <= r4_sec;
        end
    end

    // ---- stage 6: sector table into the output register
    logic [CHAN_W-1:0] n_red, n_green, n_blue;
    logic [CHAN_W-1:0] r_red, r_green, r_blue;

    always_comb begin
        case (r5_sec)
            SEC_YEL_GRN: begin n_red = cq;    n_green = r5_cv; n_blue = cp;    end
            SEC_GRN_CYN: begin n_red = cp;    n_green = r5_cv; n_blue = ct;    end
            SEC_CYN_BLU: begin n_red = cp;    n_green = cq;    n_blue = r5_cv; end
            SEC_BLU_MAG: begin n_red = ct;    n_green = cp;    n_blue = r5_cv; end
            SEC_MAG_RED: begin n_red = r5_cv; n_green = cp;    n_blue = cq;    end
            default:     begin n_red = r5_cv; n_green = ct;    n_blue = cp;    end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_rgb.valid = r_vld[STAGES-1];
    assign o_rgb.red   = r_red;
    assign o_rgb.green = r_green;
    assign o_rgb.blue  = r_blue;

endmodule

### rtl/hsv2rgb_checker.sv
// Port-level checks for the HSV to RGB converter, bound to the top level.
module hsv2rgb_checker
    import hsv2rgb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CHAN_W-1:0] i_red,
    input logic [CHAN_W-1:0] i_green,
    input logic [CHAN_W-1:0] i_blue
);

    // Output is empty on the edge after a reset cycle.
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output beat valid right after reset");

    // An empty output slot never blocks the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // Downstream ready lets the input move.
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output drains");

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_red) && $stable(i_green) && $stable(i_blue))
        else $error("output payload changed while stalled");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_hsv.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue)
);
